@@ design/s2dec_pkg.sv @@
// ----------------------------------------------------------------------------
// s2dec_pkg: shared constants for the signed integer to decimal text block
// Character codes, field widths and digit counts used by the converter.
// ----------------------------------------------------------------------------
package s2dec_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned BITCNT_W = $clog2(VALUE_W);
  localparam int unsigned LEFT_W   = $clog2(DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef logic [BCD_W-1:0] bcd_t;

endpackage

@@ design/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Converts the magnitude to BCD one bit per cycle (shift and add-3), then
// sends the characters out one per cycle, most significant first.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   start, busy, in_value[31:0]           taken when start && !busy
//  result    out_valid, out_text_char[7:0],        one-cycle strobe per char
//            out_last_char
//
//  After acceptance busy stays high through the bit-serial BCD conversion,
//  the dropping of the Z leading zeros and the move on to the digits, and the
//  sending of the D digits (D + Z = 10); a new request is taken only once busy
//  has dropped. A leading '-' goes out in the cycle after acceptance. busy is
//  high from acceptance until the last character is registered. Reset is
//  synchronous and active low and clears the control state only. The receiver
//  cannot stall: every strobed character must be taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [s2dec_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic        [s2dec_pkg::CHAR_W-1:0]  out_text_char,
  output logic                                out_last_char
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [s2dec_pkg::VALUE_W-1:0]    mag_r, mag_nxt;
  s2dec_pkg::bcd_t                  bcd_r, bcd_nxt;
  logic [s2dec_pkg::BITCNT_W-1:0]   bitcnt_r, bitcnt_nxt;
  logic [s2dec_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic                             valid_r, valid_nxt;
  logic [s2dec_pkg::CHAR_W-1:0]     char_r, char_nxt;
  logic                             last_r, last_nxt;

  s2dec_pkg::bcd_t                  bcd_adj;
  logic [3:0]                       top_digit;

  // Add 3 to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < int'(s2dec_pkg::DIGITS); i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd_r[s2dec_pkg::BCD_W-1 -: 4];

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    bcd_nxt    = bcd_r;
    bitcnt_nxt = bitcnt_r;
    left_nxt   = left_r;
    valid_nxt  = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_value[s2dec_pkg::VALUE_W-1]) begin
            mag_nxt   = -in_value;
            valid_nxt = 1'b1;
            char_nxt  = s2dec_pkg::ASCII_MINUS;
            last_nxt  = 1'b0;
          end else begin
            mag_nxt = in_value;
          end
          bcd_nxt    = '0;
          bitcnt_nxt = '0;
          left_nxt   = s2dec_pkg::LEFT_W'(s2dec_pkg::DIGITS);
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt    = {bcd_adj[s2dec_pkg::BCD_W-2:0], mag_r[s2dec_pkg::VALUE_W-1]};
        mag_nxt    = {mag_r[s2dec_pkg::VALUE_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == s2dec_pkg::BITCNT_W'(s2dec_pkg::VALUE_W - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Leading zeros are dropped, but the units digit always goes out.
        if (top_digit == 4'd0 && left_r != s2dec_pkg::LEFT_W'(1)) begin
          bcd_nxt  = {bcd_r[s2dec_pkg::BCD_W-5:0], 4'd0};
          left_nxt = left_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        valid_nxt = 1'b1;
        char_nxt  = s2dec_pkg::ASCII_ZERO + {4'd0, top_digit};
        last_nxt  = (left_r == s2dec_pkg::LEFT_W'(1));
        bcd_nxt   = {bcd_r[s2dec_pkg::BCD_W-5:0], 4'd0};
        left_nxt  = left_r - 1'b1;
        if (left_r == s2dec_pkg::LEFT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    mag_r    <= mag_nxt;
    bcd_r    <= bcd_nxt;
    bitcnt_r <= bitcnt_nxt;
    left_r   <= left_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == s2dec_pkg::ASCII_MINUS) ||
                  ((out_text_char >= s2dec_pkg::ASCII_ZERO) &&
                   (out_text_char <= s2dec_pkg::ASCII_NINE)))
    else $error("character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_char == s2dec_pkg::ASCII_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |=> out_valid)
    else $error("digit emission without strobe");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (left_r != '0))
    else $error("digit count underflow");

endmodule
